### sv/luhn_pkg.sv
// shared types and constants for the luhn card number classifier
// no dependencies; used by luhn_card_number_classifier_top

package luhn_pkg;

	localparam int CARD_W      = 63;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 8;
	localparam int DIGITS      = 19;
	localparam int BCD_W       = DIGITS * 4;
	localparam int BIT_CNT_W   = 6;
	localparam int DIG_CNT_W   = 5;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(CARD_W - 1);
	localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(DIGITS - 1);

	localparam logic [DIG_CNT_W-1:0] LEN_VISA_SHORT = 5'd13;
	localparam logic [DIG_CNT_W-1:0] LEN_AMEX       = 5'd15;
	localparam logic [DIG_CNT_W-1:0] LEN_LONG       = 5'd16;

	typedef logic [3:0] digit_t;

	typedef enum logic [1:0] {
		CLASS_INVALID    = 2'd0,
		CLASS_AMEX       = 2'd1,
		CLASS_MASTERCARD = 2'd2,
		CLASS_VISA       = 2'd3
	} card_class_t;

endpackage

### sv/luhn_card_number_classifier_top.sv
// luhn card number classifier, top level
// depends on luhn_pkg

// One word in, one word out. An accepted card number is converted to 19 BCD
// digits by a shift-and-add-3 unit, one input bit per cycle, then the digits
// are scanned from the right, one per cycle, through a single mod-10
// accumulator that also records the digit count and the two leading digits;
// the ST_EVAL state then forms the class. s_tready stays low from acceptance
// until the result has been taken.
module luhn_card_number_classifier_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [luhn_pkg::IN_TDATA_W-1:0]     s_tdata,   // [62:0] card_number
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [luhn_pkg::OUT_TDATA_W-1:0]    m_tdata    // [1:0] card_class
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EVAL
	} state_t;

	state_t                              state_q;
	logic [luhn_pkg::CARD_W-1:0]         bin_q;
	logic [luhn_pkg::BCD_W-1:0]          bcd_q;
	logic [luhn_pkg::BIT_CNT_W-1:0]      bit_cnt_q;
	logic [luhn_pkg::DIG_CNT_W-1:0]      dig_cnt_q;
	logic [luhn_pkg::DIG_CNT_W-1:0]      len_q;
	luhn_pkg::digit_t                    sum_q;
	luhn_pkg::digit_t                    prev_q;
	luhn_pkg::digit_t                    first_q;
	luhn_pkg::digit_t                    second_q;
	logic                                m_tvalid_q;
	luhn_pkg::card_class_t               class_q;

	logic [luhn_pkg::BCD_W-1:0]          bcd_adj;
	luhn_pkg::digit_t                    digit;
	luhn_pkg::digit_t                    contrib;
	logic [4:0]                          sum_raw;
	luhn_pkg::digit_t                    sum_next;
	luhn_pkg::card_class_t               class_next;
	logic                                is_amex;
	logic                                is_mc;
	logic                                is_visa;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < luhn_pkg::DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// luhn contribution of the current digit, accumulated mod 10
	always_comb begin
		digit = bcd_q[3:0];
		if (dig_cnt_q[0]) begin
			if (digit < 4'd5) begin
				contrib = {digit[2:0], 1'b0};
			end else begin
				contrib = 4'({digit, 1'b0} - 5'd9);
			end
		end else begin
			contrib = digit;
		end
		sum_raw = {1'b0, sum_q} + {1'b0, contrib};
		if (sum_raw >= 5'd10) begin
			sum_next = 4'(sum_raw - 5'd10);
		end else begin
			sum_next = sum_raw[3:0];
		end
	end

	always_comb begin
		is_amex = (len_q == luhn_pkg::LEN_AMEX) && (first_q == 4'd3)
			&& ((second_q == 4'd4) || (second_q == 4'd7));
		is_mc   = (len_q == luhn_pkg::LEN_LONG) && (first_q == 4'd5)
			&& (second_q >= 4'd1) && (second_q <= 4'd5);
		is_visa = ((len_q == luhn_pkg::LEN_VISA_SHORT) || (len_q == luhn_pkg::LEN_LONG))
			&& (first_q == 4'd4);
		if (sum_q != 4'd0) begin
			class_next = luhn_pkg::CLASS_INVALID;
		end else if (is_amex) begin
			class_next = luhn_pkg::CLASS_AMEX;
		end else if (is_mc) begin
			class_next = luhn_pkg::CLASS_MASTERCARD;
		end else if (is_visa) begin
			class_next = luhn_pkg::CLASS_VISA;
		end else begin
			class_next = luhn_pkg::CLASS_INVALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			bit_cnt_q  <= '0;
			dig_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (m_tvalid_q && m_tready) begin
						m_tvalid_q <= 1'b0;
					end
					if (s_tvalid && !m_tvalid_q) begin
						bin_q     <= s_tdata[luhn_pkg::CARD_W-1:0];
						bcd_q     <= '0;
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[luhn_pkg::BCD_W-2:0], bin_q[luhn_pkg::CARD_W-1]};
					bin_q     <= {bin_q[luhn_pkg::CARD_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == luhn_pkg::LAST_BIT) begin
						dig_cnt_q <= '0;
						len_q     <= '0;
						sum_q     <= '0;
						prev_q    <= '0;
						first_q   <= '0;
						second_q  <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					bcd_q     <= {4'd0, bcd_q[luhn_pkg::BCD_W-1:4]};
					sum_q     <= sum_next;
					prev_q    <= digit;
					dig_cnt_q <= dig_cnt_q + 1'b1;
					// most significant nonzero digit seen so far sets length and prefix
					if (digit != 4'd0) begin
						len_q    <= dig_cnt_q + 1'b1;
						first_q  <= digit;
						second_q <= prev_q;
					end
					if (dig_cnt_q == luhn_pkg::LAST_DIGIT) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					class_q    <= class_next;
					m_tvalid_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(luhn_pkg::OUT_TDATA_W - 2){1'b0}}, class_q};

endmodule
